// ===== rtl/core/kaars_pkg.sv =====
// shared types and constants for the keepalive and ack retry supervisor
// no dependencies; every other file in rtl/core imports this package
package kaars_pkg;

	localparam int MAX_RETRIES = 3;
	localparam int RETRY_W     = $clog2(MAX_RETRIES + 1);
	localparam int TIME_W      = 32;
	localparam int KA_W        = 16;
	localparam int PW_W        = 16;
	localparam int AW_W        = 32;
	localparam int MODE_W      = 3;
	localparam int STATUS_W    = 2;
	localparam int RDONE_W     = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK      = 3'd0,
		MODE_RX_FRAME  = 3'd1,
		MODE_TX_PACKET = 3'd2,
		MODE_PUB_START = 3'd3,
		MODE_PUBACK    = 3'd4,
		MODE_PINGRESP  = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 2'd0,
		ST_PING_TIMEOUT  = 2'd1,
		ST_ACK_EXHAUSTED = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEEPALIVE = 2'd0,
		REG_PING_WAIT = 2'd1,
		REG_ACK_WAIT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [KA_W-1:0] keepalive_interval;
		logic [PW_W-1:0] ping_wait_limit;
		logic [AW_W-1:0] ack_wait_limit;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]  last_receive_time;
		logic [TIME_W-1:0]  last_send_time;
		logic [TIME_W-1:0]  ping_sent_time;
		logic               ping_pending;
		logic               ack_pending;
		logic [TIME_W-1:0]  ack_sent_time;
		logic [RETRY_W-1:0] retry_count;
	} sup_state_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                ping_request;
		logic                resend_publish;
		logic                ping_waiting;
		logic                ack_waiting;
		logic [RDONE_W-1:0]  retries_done;
	} result_t;

endpackage

// ===== rtl/core/kaars_cfg.sv =====
// configuration register file: keepalive interval, ping wait and ack wait limits
// depends on kaars_pkg
module kaars_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [kaars_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [kaars_pkg::CFG_DATA_W-1:0]    wr_data,
	output kaars_pkg::cfg_t                     cfg
);
	import kaars_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_KEEPALIVE: cfg_q.keepalive_interval <= wr_data[KA_W-1:0];
				REG_PING_WAIT: cfg_q.ping_wait_limit    <= wr_data[PW_W-1:0];
				REG_ACK_WAIT:  cfg_q.ack_wait_limit     <= wr_data[AW_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/kaars_eval.sv =====
// next-state and result logic for one event against the supervisor state
// depends on kaars_pkg; purely combinational
module kaars_eval (
	input  kaars_pkg::cfg_t                   cfg,
	input  kaars_pkg::sup_state_t             cur,
	input  logic [kaars_pkg::MODE_W-1:0]      mode,
	input  logic [kaars_pkg::TIME_W-1:0]      now_time,
	output kaars_pkg::sup_state_t             nxt,
	output kaars_pkg::result_t                res
);
	import kaars_pkg::*;

	logic [TIME_W-1:0] last_act;
	logic              ka_on;
	logic              ping_due;
	logic              ping_late;
	logic              ack_late;
	logic              skip_ack;

	always_comb begin
		last_act  = (cur.last_receive_time > cur.last_send_time) ?
			cur.last_receive_time : cur.last_send_time;
		ka_on     = (cfg.keepalive_interval != '0);
		ping_due  = !cur.ping_pending &&
			((now_time - last_act) >= TIME_W'(cfg.keepalive_interval));
		ping_late = cur.ping_pending &&
			((now_time - cur.ping_sent_time) >= TIME_W'(cfg.ping_wait_limit));
		ack_late  = cur.ack_pending &&
			((now_time - cur.ack_sent_time) >= cfg.ack_wait_limit);
		skip_ack  = 1'b0;

		nxt = cur;
		res = '0;

		case (mode)
			MODE_TICK: begin
				if (ka_on) begin
					// first tick after startup seeds both times but still compares against zero
					if (last_act == '0) begin
						nxt.last_receive_time = now_time;
						nxt.last_send_time    = now_time;
					end
					if (ping_due) begin
						res.ping_request   = 1'b1;
						nxt.ping_sent_time = now_time;
						nxt.ping_pending   = 1'b1;
					end else if (ping_late) begin
						nxt.ping_pending = 1'b0;
						res.status       = ST_PING_TIMEOUT;
						skip_ack         = 1'b1;
					end
				end
				if (!skip_ack && ack_late) begin
					if (cur.retry_count < RETRY_W'(MAX_RETRIES)) begin
						res.resend_publish = 1'b1;
						nxt.ack_sent_time  = now_time;
						nxt.retry_count    = cur.retry_count + RETRY_W'(1);
					end else begin
						nxt.ack_pending   = 1'b0;
						nxt.ack_sent_time = '0;
						nxt.retry_count   = '0;
						res.status        = ST_ACK_EXHAUSTED;
					end
				end
			end
			MODE_RX_FRAME: begin
				nxt.last_receive_time = now_time;
			end
			MODE_TX_PACKET: begin
				nxt.last_send_time = now_time;
				// stamp the first send of the pending publish
				if (cur.ack_pending && cur.ack_sent_time == '0) begin
					nxt.ack_sent_time = now_time;
				end
			end
			MODE_PUB_START: begin
				nxt.ack_pending   = 1'b1;
				nxt.ack_sent_time = '0;
				nxt.retry_count   = '0;
			end
			MODE_PUBACK: begin
				nxt.ack_pending   = 1'b0;
				nxt.ack_sent_time = '0;
				nxt.retry_count   = '0;
			end
			MODE_PINGRESP: begin
				nxt.ping_pending = 1'b0;
			end
			default: ;
		endcase

		res.ping_waiting = nxt.ping_pending;
		res.ack_waiting  = nxt.ack_pending;
		res.retries_done = RDONE_W'(nxt.retry_count);
	end

endmodule

// ===== rtl/core/keepalive_and_ack_retry_supervisor.sv =====
// keepalive and ack retry supervisor: an accepted input beat goes through the input
// register, then the result register, to its result beat; throughput one beat per
// cycle unless out_stall holds a valid result, set by the state update between them.
// reset clears the config registers, the supervisor state and both valid flags.
// depends on kaars_pkg, kaars_cfg, kaars_eval
module keepalive_and_ack_retry_supervisor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [kaars_pkg::MODE_W-1:0]        mode,
	input  logic [kaars_pkg::TIME_W-1:0]        now_time,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [kaars_pkg::STATUS_W-1:0]      status,
	output logic                                ping_request,
	output logic                                resend_publish,
	output logic                                ping_waiting,
	output logic                                ack_waiting,
	output logic [kaars_pkg::RDONE_W-1:0]       retries_done,
	input  logic                                wr_en,
	input  logic [kaars_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [kaars_pkg::CFG_DATA_W-1:0]    wr_data
);
	import kaars_pkg::*;

	cfg_t              cfg;
	sup_state_t        state_q;
	sup_state_t        state_nxt;
	result_t           res_nxt;
	result_t           res_q;
	logic              valid_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [TIME_W-1:0] now_s1;
	logic              out_valid_q;
	logic              advance;

	kaars_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	kaars_eval u_eval (
		.cfg      (cfg),
		.cur      (state_q),
		.mode     (mode_s1),
		.now_time (now_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	// the input beat moves on whenever the result register is free or being drained
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode;
			now_s1  <= now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign ping_request   = res_q.ping_request;
	assign resend_publish = res_q.resend_publish;
	assign ping_waiting   = res_q.ping_waiting;
	assign ack_waiting    = res_q.ack_waiting;
	assign retries_done   = res_q.retries_done;

endmodule

// ===== rtl/core/kaars_checker.sv =====
// port-level checks for the keepalive and ack retry supervisor, bound to the top level
// depends on kaars_pkg and keepalive_and_ack_retry_supervisor
module kaars_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [kaars_pkg::STATUS_W-1:0]      status,
	input  logic                                ping_request,
	input  logic                                resend_publish,
	input  logic                                ping_waiting,
	input  logic                                ack_waiting,
	input  logic [kaars_pkg::RDONE_W-1:0]       retries_done
);
	import kaars_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(ping_request) && $stable(resend_publish) && $stable(retries_done))
		else $error("result beat changed while stalled");

	// a ping request leaves a ping outstanding and never comes with a timeout
	a_ping_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ping_request |-> ping_waiting && status != ST_PING_TIMEOUT)
		else $error("ping request without ping outstanding");

	// a resend keeps the publish pending and counts at least one retry
	a_resend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && resend_publish |->
		ack_waiting && retries_done != '0 && status == ST_OK)
		else $error("resend with inconsistent ack state");

	// giving up on a publish clears it completely
	a_exhaust: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ACK_EXHAUSTED |->
		!ack_waiting && retries_done == '0 && !resend_publish)
		else $error("ack exhaustion left publish state behind");

	// a ping timeout clears the ping flag and skips the ack check
	a_ping_to: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_PING_TIMEOUT |->
		!ping_waiting && !resend_publish && !ping_request)
		else $error("ping timeout with inconsistent flags");

endmodule

bind keepalive_and_ack_retry_supervisor kaars_checker u_kaars_checker (.*);
